// ===== sv/ccs_pkg.sv =====
`timescale 1ns / 1ps

package ccs_pkg;

    localparam int GAIN_W     = 10;
    localparam int THR_W      = 16;
    localparam int MARGIN_W   = 8;
    localparam int NORM_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]   GAIN_RED_RST     = 10'd256;
    localparam logic [GAIN_W-1:0]   GAIN_GREEN_RST   = 10'd358;
    localparam logic [GAIN_W-1:0]   GAIN_BLUE_RST    = 10'd461;
    localparam logic [THR_W-1:0]    BLACK_THR_RST    = 16'd800;
    localparam logic [THR_W-1:0]    WHITE_THR_RST    = 16'd2200;
    localparam logic [MARGIN_W-1:0] BRIGHT_MARGIN_RST = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_RED      = 3'd0,
        CFG_GAIN_GREEN    = 3'd1,
        CFG_GAIN_BLUE     = 3'd2,
        CFG_BLACK_THR     = 3'd3,
        CFG_WHITE_THR     = 3'd4,
        CFG_BRIGHT_MARGIN = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEC_RED   = 3'd0,
        SEC_GREEN = 3'd1,
        SEC_BLUE  = 3'd2,
        SEC_WHITE = 3'd3,
        SEC_NONE  = 3'd4
    } t_sector;

    typedef enum logic [1:0] {
        BRT_RED   = 2'd0,
        BRT_GREEN = 2'd1,
        BRT_BLUE  = 2'd2,
        BRT_NONE  = 2'd3
    } t_bright;

    typedef enum logic [1:0] {
        NEU_BLACK = 2'd0,
        NEU_WHITE = 2'd1,
        NEU_GRAY  = 2'd2
    } t_neutral;

    typedef struct packed {
        t_sector  sector;
        t_neutral neutral;
    } t_side;

endpackage

// ===== sv/color_sensor_classifier_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// input     in         start / busy                 i_red_raw, i_green_raw, i_blue_raw,
//                                                   i_clear_raw
// result    out        o_valid (one-cycle strobe)   o_red_norm, o_green_norm, o_blue_norm,
//                                                   o_sector, o_bright_class, o_neutral_class
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item is accepted every cycle; busy is never raised.
// Each result passes through the gain multiply and scale registers, the restoring
// divider stages (one quotient bit per stage), and the bright class and output
// register.
// Reset is synchronous and active low; it clears the valid pipeline and loads the
// register defaults. The result side cannot stall, so the pipeline never holds.

module color_sensor_classifier_top
    import ccs_pkg::*;
#(
    parameter int SAMPLE_BITS        = 16,
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] i_red_raw,
    input  logic [SAMPLE_BITS-1:0] i_green_raw,
    input  logic [SAMPLE_BITS-1:0] i_blue_raw,
    input  logic [SAMPLE_BITS-1:0] i_clear_raw,
    output logic                   o_valid,
    output logic [NORM_W-1:0]      o_red_norm,
    output logic [NORM_W-1:0]      o_green_norm,
    output logic [NORM_W-1:0]      o_blue_norm,
    output logic [2:0]             o_sector,
    output logic [1:0]             o_bright_class,
    output logic [1:0]             o_neutral_class,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int NUM_W  = PROD_W + NORM_W;
    localparam int DEN_W  = SAMPLE_BITS + GAIN_FRACTION_BITS;
    localparam int LAT    = 2 + NORM_W + 1;

    logic [GAIN_W-1:0]   r_gain_red;
    logic [GAIN_W-1:0]   r_gain_green;
    logic [GAIN_W-1:0]   r_gain_blue;
    logic [THR_W-1:0]    r_black_thr;
    logic [THR_W-1:0]    r_white_thr;
    logic [MARGIN_W-1:0] r_margin;

    logic                accept;
    logic                front_valid;
    logic [NUM_W-1:0]    num_red;
    logic [NUM_W-1:0]    num_green;
    logic [NUM_W-1:0]    num_blue;
    logic [DEN_W-1:0]    den;
    logic                den_zero;
    t_side               front_side;

    logic [NORM_W-1:0]   red_norm;
    logic [NORM_W-1:0]   green_norm;
    logic [NORM_W-1:0]   blue_norm;

    logic [NORM_W-1:0]   r_vld_pipe;
    t_side               r_side_pipe [NORM_W];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_red   <= GAIN_RED_RST;
            r_gain_green <= GAIN_GREEN_RST;
            r_gain_blue  <= GAIN_BLUE_RST;
            r_black_thr  <= BLACK_THR_RST;
            r_white_thr  <= WHITE_THR_RST;
            r_margin     <= BRIGHT_MARGIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_RED:      r_gain_red   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_GREEN:    r_gain_green <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_BLUE:     r_gain_blue  <= i_cfg_data[GAIN_W-1:0];
                CFG_BLACK_THR:     r_black_thr  <= i_cfg_data[THR_W-1:0];
                CFG_WHITE_THR:     r_white_thr  <= i_cfg_data[THR_W-1:0];
                CFG_BRIGHT_MARGIN: r_margin     <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    ccs_front #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_red_raw    (i_red_raw),
        .i_green_raw  (i_green_raw),
        .i_blue_raw   (i_blue_raw),
        .i_clear_raw  (i_clear_raw),
        .i_gain_red   (r_gain_red),
        .i_gain_green (r_gain_green),
        .i_gain_blue  (r_gain_blue),
        .i_black_thr  (r_black_thr),
        .i_white_thr  (r_white_thr),
        .o_valid      (front_valid),
        .o_num_red    (num_red),
        .o_num_green  (num_green),
        .o_num_blue   (num_blue),
        .o_den        (den),
        .o_zero       (den_zero),
        .o_side       (front_side)
    );

    ccs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_red (
        .i_clk  (i_clk),
        .i_num  (num_red),
        .i_den  (den),
        .i_zero (den_zero),
        .o_norm (red_norm)
    );

    ccs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_green (
        .i_clk  (i_clk),
        .i_num  (num_green),
        .i_den  (den),
        .i_zero (den_zero),
        .o_norm (green_norm)
    );

    ccs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_blue (
        .i_clk  (i_clk),
        .i_num  (num_blue),
        .i_den  (den),
        .i_zero (den_zero),
        .o_norm (blue_norm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[NORM_W-2:0], front_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_pipe[0] <= front_side;
        for (int i = 1; i < NORM_W; i++) begin
            r_side_pipe[i] <= r_side_pipe[i-1];
        end
    end

    ccs_classify u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_vld_pipe[NORM_W-1]),
        .i_red_norm      (red_norm),
        .i_green_norm    (green_norm),
        .i_blue_norm     (blue_norm),
        .i_side          (r_side_pipe[NORM_W-1]),
        .i_margin        (r_margin),
        .o_valid         (o_valid),
        .o_red_norm      (o_red_norm),
        .o_green_norm    (o_green_norm),
        .o_blue_norm     (o_blue_norm),
        .o_sector        (o_sector),
        .o_bright_class  (o_bright_class),
        .o_neutral_class (o_neutral_class)
    );

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("accepted item produced no result at the expected cycle");

    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted item");

    a_black_sector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_neutral_class == NEU_BLACK) |-> o_sector == SEC_NONE)
        else $error("black reading carries a color sector");

    a_white_sector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_neutral_class == NEU_WHITE) |-> o_sector == SEC_WHITE)
        else $error("white reading carries a non-white sector");

endmodule

// ===== sv/ccs_front.sv =====
`timescale 1ns / 1ps

module ccs_front
    import ccs_pkg::*;
#(
    parameter int SAMPLE_BITS        = 16,
    parameter int GAIN_FRACTION_BITS = 8,
    localparam int PROD_W = SAMPLE_BITS + GAIN_W,
    localparam int NUM_W  = PROD_W + NORM_W,
    localparam int DEN_W  = SAMPLE_BITS + GAIN_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_red_raw,
    input  logic [SAMPLE_BITS-1:0] i_green_raw,
    input  logic [SAMPLE_BITS-1:0] i_blue_raw,
    input  logic [SAMPLE_BITS-1:0] i_clear_raw,
    input  logic [GAIN_W-1:0]      i_gain_red,
    input  logic [GAIN_W-1:0]      i_gain_green,
    input  logic [GAIN_W-1:0]      i_gain_blue,
    input  logic [THR_W-1:0]       i_black_thr,
    input  logic [THR_W-1:0]       i_white_thr,
    output logic                   o_valid,
    output logic [NUM_W-1:0]       o_num_red,
    output logic [NUM_W-1:0]       o_num_green,
    output logic [NUM_W-1:0]       o_num_blue,
    output logic [DEN_W-1:0]       o_den,
    output logic                   o_zero,
    output t_side                  o_side
);

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    logic                   r_v1;
    logic [PROD_W-1:0]      r_prod_red;
    logic [PROD_W-1:0]      r_prod_green;
    logic [PROD_W-1:0]      r_prod_blue;
    logic [SAMPLE_BITS-1:0] r_clear;
    logic                   r_black;
    logic                   r_white;

    logic [PROD_W-1:0]      n_prod_red;
    logic [PROD_W-1:0]      n_prod_green;
    logic [PROD_W-1:0]      n_prod_blue;
    logic                   n_black;
    logic                   n_white;

    logic                   r_v2;
    logic [NUM_W-1:0]       r_num_red;
    logic [NUM_W-1:0]       r_num_green;
    logic [NUM_W-1:0]       r_num_blue;
    logic [DEN_W-1:0]       r_den;
    logic                   r_zero;
    t_side                  r_side;
    t_side                  n_side;

    always_comb begin
        n_prod_red   = PROD_W'(i_red_raw) * PROD_W'(i_gain_red);
        n_prod_green = PROD_W'(i_green_raw) * PROD_W'(i_gain_green);
        n_prod_blue  = PROD_W'(i_blue_raw) * PROD_W'(i_gain_blue);
        n_black      = CMP_W'(i_clear_raw) < CMP_W'(i_black_thr);
        n_white      = CMP_W'(i_clear_raw) > CMP_W'(i_white_thr);
    end

    always_comb begin
        if (r_black) begin
            n_side.sector  = SEC_NONE;
            n_side.neutral = NEU_BLACK;
        end else if (r_white) begin
            n_side.sector  = SEC_WHITE;
            n_side.neutral = NEU_WHITE;
        end else begin
            n_side.neutral = NEU_GRAY;
            if (r_prod_red > r_prod_green && r_prod_red > r_prod_blue) begin
                n_side.sector = SEC_RED;
            end else if (r_prod_green > r_prod_red && r_prod_green > r_prod_blue) begin
                n_side.sector = SEC_GREEN;
            end else if (r_prod_blue > r_prod_red && r_prod_blue > r_prod_green) begin
                n_side.sector = SEC_BLUE;
            end else begin
                n_side.sector = SEC_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_red   <= n_prod_red;
        r_prod_green <= n_prod_green;
        r_prod_blue  <= n_prod_blue;
        r_clear      <= i_clear_raw;
        r_black      <= n_black;
        r_white      <= n_white;

        // Multiply by 255 as a shift and a subtract.
        r_num_red    <= (NUM_W'(r_prod_red) << NORM_W) - NUM_W'(r_prod_red);
        r_num_green  <= (NUM_W'(r_prod_green) << NORM_W) - NUM_W'(r_prod_green);
        r_num_blue   <= (NUM_W'(r_prod_blue) << NORM_W) - NUM_W'(r_prod_blue);
        r_den        <= DEN_W'(r_clear) << GAIN_FRACTION_BITS;
        r_zero       <= (r_clear == '0);
        r_side       <= n_side;
    end

    assign o_valid     = r_v2;
    assign o_num_red   = r_num_red;
    assign o_num_green = r_num_green;
    assign o_num_blue  = r_num_blue;
    assign o_den       = r_den;
    assign o_zero      = r_zero;
    assign o_side      = r_side;

endmodule

// ===== sv/ccs_divider.sv =====
`timescale 1ns / 1ps

module ccs_divider
    import ccs_pkg::*;
#(
    parameter int NUM_W = 34,
    parameter int DEN_W = 24
) (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic              i_zero,
    output logic [NORM_W-1:0] o_norm
);

    localparam int CW = (NUM_W > DEN_W + NORM_W) ? NUM_W : DEN_W + NORM_W;

    logic [CW-1:0]     r_rem  [NORM_W-1];
    logic [DEN_W-1:0]  r_den  [NORM_W-1];
    logic [NORM_W-1:0] r_q    [NORM_W];
    logic              r_sat  [NORM_W];
    logic              r_zero [NORM_W];

    for (genvar s = 0; s < NORM_W; s++) begin : g_step
        localparam int K = NORM_W - 1 - s;

        logic [CW-1:0]     rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [NORM_W-1:0] q_in;
        logic              sat_in;
        logic              zero_in;
        logic [CW-1:0]     dsh;
        logic              take;
        logic [CW-1:0]     n_rem;
        logic [NORM_W-1:0] n_q;

        if (s == 0) begin : g_first
            // A quotient above 255 is detected up front and saturates.
            assign rem_in  = CW'(i_num);
            assign den_in  = i_den;
            assign q_in    = '0;
            assign sat_in  = CW'(i_num) >= (CW'(i_den) << NORM_W);
            assign zero_in = i_zero;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign q_in    = r_q[s-1];
            assign sat_in  = r_sat[s-1];
            assign zero_in = r_zero[s-1];
        end

        always_comb begin
            dsh    = CW'(den_in) << K;
            take   = rem_in >= dsh;
            n_rem  = take ? rem_in - dsh : rem_in;
            n_q    = q_in;
            n_q[K] = take;
        end

        always_ff @(posedge i_clk) begin
            r_q[s]    <= n_q;
            r_sat[s]  <= sat_in;
            r_zero[s] <= zero_in;
        end

        if (s < NORM_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_norm = r_zero[NORM_W-1] ? '0 :
                    r_sat[NORM_W-1]  ? '1 : r_q[NORM_W-1];

endmodule

// ===== sv/ccs_classify.sv =====
`timescale 1ns / 1ps

module ccs_classify
    import ccs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [NORM_W-1:0]   i_red_norm,
    input  logic [NORM_W-1:0]   i_green_norm,
    input  logic [NORM_W-1:0]   i_blue_norm,
    input  t_side               i_side,
    input  logic [MARGIN_W-1:0] i_margin,
    output logic                o_valid,
    output logic [NORM_W-1:0]   o_red_norm,
    output logic [NORM_W-1:0]   o_green_norm,
    output logic [NORM_W-1:0]   o_blue_norm,
    output logic [2:0]          o_sector,
    output logic [1:0]          o_bright_class,
    output logic [1:0]          o_neutral_class
);

    localparam int SW = ((NORM_W > MARGIN_W) ? NORM_W : MARGIN_W) + 1;

    logic              r_valid;
    logic [NORM_W-1:0] r_red_norm;
    logic [NORM_W-1:0] r_green_norm;
    logic [NORM_W-1:0] r_blue_norm;
    t_side             r_side;
    t_bright           r_bright;

    logic [SW-1:0] rn;
    logic [SW-1:0] gn;
    logic [SW-1:0] bn;
    logic [SW-1:0] m;
    t_bright       n_bright;

    always_comb begin
        rn = SW'(i_red_norm);
        gn = SW'(i_green_norm);
        bn = SW'(i_blue_norm);
        m  = SW'(i_margin);
        if (rn > gn + m && rn > bn + m) begin
            n_bright = BRT_RED;
        end else if (gn > rn + m && gn > bn + m) begin
            n_bright = BRT_GREEN;
        end else if (bn > rn + m && bn > gn + m) begin
            n_bright = BRT_BLUE;
        end else begin
            n_bright = BRT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red_norm   <= i_red_norm;
        r_green_norm <= i_green_norm;
        r_blue_norm  <= i_blue_norm;
        r_side       <= i_side;
        r_bright     <= n_bright;
    end

    assign o_valid         = r_valid;
    assign o_red_norm      = r_red_norm;
    assign o_green_norm    = r_green_norm;
    assign o_blue_norm     = r_blue_norm;
    assign o_sector        = r_side.sector;
    assign o_bright_class  = r_bright;
    assign o_neutral_class = r_side.neutral;

endmodule
